// ----- rtl/core/ridsf_pkg.sv -----
// ridsf_pkg: shared types, codes and helper functions of the ID string finder.
// No dependencies; used by ridsf_chain, rom_id_string_finder and ridsf_checker.
`default_nettype none

package ridsf_pkg;

    localparam int PATTERN_BYTES = 16;
    localparam int PATTERN_BITS  = 8 * PATTERN_BYTES;
    localparam int USED_LEN_W    = 6;
    localparam int LENGTH_W      = 17;
    localparam int START_W       = 16;

    localparam logic [1:0] CFG_PATTERN_LOW    = 2'd0;
    localparam logic [1:0] CFG_PATTERN_HIGH   = 2'd1;
    localparam logic [1:0] CFG_PATTERN_LENGTH = 2'd2;

    localparam logic [1:0] STATUS_NOT_FOUND = 2'd0;
    localparam logic [1:0] STATUS_FOUND     = 2'd1;
    localparam logic [1:0] STATUS_REJECTED  = 2'd2;

    localparam logic [1:0] PH_SEARCH = 2'd0;
    localparam logic [1:0] PH_EXTEND = 2'd1;
    localparam logic [1:0] PH_IDLE   = 2'd2;

    localparam logic [7:0] CHAR_NUL   = 8'h00;
    localparam logic [7:0] CHAR_CR    = 8'h0D;
    localparam logic [7:0] CHAR_LF    = 8'h0A;
    localparam logic [7:0] CHAR_SPACE = 8'h20;
    localparam logic [7:0] CHAR_TILDE = 8'h7E;

    typedef struct packed {
        logic hit;
        logic pattern_printable;
        logic prev_printable;
    } chain_status_t;

    function automatic logic is_printable(input logic [7:0] b);
        return (b >= CHAR_SPACE) && (b <= CHAR_TILDE);
    endfunction

    function automatic logic [7:0] pattern_byte(input logic [PATTERN_BITS-1:0] pat,
                                                input int k);
        logic [7:0] res;
        res = 8'h00;
        if (k >= 0 && k < PATTERN_BYTES)
        begin
            res = 8'(pat >> (8 * k));
        end
        return res;
    endfunction

endpackage

`default_nettype wire

// ----- rtl/core/ridsf_cell.sv -----
// ridsf_cell: one byte of the recent-byte shift line with its pattern comparator.
// Depends on nothing; instantiated by ridsf_chain.
`default_nettype none

module ridsf_cell (
    input  wire logic       clk,
    input  wire logic       shift_en,
    input  wire logic [7:0] byte_in,
    input  wire logic [7:0] expected,
    input  wire logic       active,
    output logic      [7:0] byte_out,
    output logic            hit
);

    logic [7:0] byte_reg;

    always_ff @(posedge clk)
    begin
        if (shift_en)
        begin
            byte_reg <= byte_in;
        end
    end

    assign byte_out = byte_reg;
    assign hit      = !active || (byte_in == expected);

endmodule

`default_nettype wire

// ----- rtl/core/ridsf_chain.sv -----
// ridsf_chain: row of compare cells that matches the pattern against recent bytes.
// Depends on ridsf_pkg and ridsf_cell.
`default_nettype none

module ridsf_chain #(
    parameter int PATTERN_MAX = 16
) (
    input  wire logic                             clk,
    input  wire logic                             shift_en,
    input  wire logic [7:0]                       data_byte,
    input  wire logic [ridsf_pkg::PATTERN_BITS-1:0] pattern,
    input  wire logic [ridsf_pkg::USED_LEN_W-1:0] used_len,
    output ridsf_pkg::chain_status_t              chain_status
);

    logic [7:0]             link [PATTERN_MAX+1];
    logic [7:0]             expected [PATTERN_MAX];
    logic [PATTERN_MAX-1:0] active;
    logic [PATTERN_MAX-1:0] hit;
    logic [PATTERN_MAX-1:0] pat_ok;

    assign link[0] = data_byte;

    for (genvar j = 0; j < PATTERN_MAX; j++)
    begin : g_cell
        assign active[j]   = 32'(j) < 32'(used_len);
        assign expected[j] = ridsf_pkg::pattern_byte(pattern,
                                 int'(used_len) - 1 - j);
        assign pat_ok[j]   = (32'(j) >= 32'(used_len)) ||
                             ridsf_pkg::is_printable(ridsf_pkg::pattern_byte(pattern, j));

        ridsf_cell u_cell (
            .clk      (clk),
            .shift_en (shift_en),
            .byte_in  (link[j]),
            .expected (expected[j]),
            .active   (active[j]),
            .byte_out (link[j+1]),
            .hit      (hit[j])
        );
    end

    assign chain_status.hit               = &hit;
    assign chain_status.pattern_printable = &pat_ok;
    assign chain_status.prev_printable    = ridsf_pkg::is_printable(link[1]);

endmodule

`default_nettype wire

// ----- rtl/core/rom_id_string_finder.sv -----
// rom_id_string_finder: top level of the ID string finder.
// Depends on ridsf_pkg and ridsf_chain.
//
// Takes one byte of a memory block per cycle and returns one result per block:
// not found, found (start and space-trimmed length) or rejected. Every byte is
// handled in the cycle it is accepted: the byte enters a row of compare cells
// whose matches are combined with the run and length tracking in one step, so
// the block sustains one byte per clock. The result sits in an output register;
// input is stalled only while that register holds a result that is not taken.
// The pattern registers are written through the configuration channel, which
// is always ready; write them only while the block is quiet.
`default_nettype none

module rom_id_string_finder #(
    parameter int PATTERN_MAX   = 16,
    parameter int BLOCK_BYTES   = 65536,
    parameter int FORWARD_LIMIT = 256
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [63:0] cfg_data,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic [7:0]  data_byte,
    input  wire logic        last,
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic [1:0]       status,
    output logic [15:0]      string_start,
    output logic [16:0]      string_length
);

    localparam int POS_W = (BLOCK_BYTES > 1) ? $clog2(BLOCK_BYTES) : 1;
    localparam int FL_W  = $clog2(BLOCK_BYTES + 1);
    localparam int UL_W  = ridsf_pkg::USED_LEN_W;

    logic [63:0]      pattern_low_reg;
    logic [63:0]      pattern_high_reg;
    logic [4:0]       pattern_length_reg;
    logic [UL_W-1:0]  used_len;

    logic [POS_W-1:0] position_reg, position_next;
    logic [POS_W-1:0] run_begin_reg, run_begin_next;
    logic [1:0]       phase_reg, phase_next;
    logic [FL_W-1:0]  found_length_reg, found_length_next;
    logic [FL_W-1:0]  trailing_reg, trailing_next;

    logic             out_valid_reg, out_valid_next;
    logic [1:0]       status_reg, status_next;
    logic [POS_W-1:0] start_reg, start_next;
    logic [FL_W-1:0]  length_reg, length_next;
    logic             emit;

    ridsf_pkg::chain_status_t chain_status;

    logic             accept;
    logic             eff_last;
    logic             printable;
    logic             is_term;
    logic [FL_W-1:0]  p1;
    logic [FL_W-1:0]  trail_s;
    logic [POS_W-1:0] run_s;
    logic             match;
    logic [POS_W-1:0] mstart;
    logic [POS_W-1:0] start_s;
    logic [FL_W-1:0]  found_s;
    logic [FL_W-1:0]  trail_c;
    logic             grow;

    assign cfg_ready = 1'b1;
    assign in_ready  = !out_valid_reg || out_ready;
    assign accept    = in_valid && in_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pattern_low_reg    <= '0;
            pattern_high_reg   <= '0;
            pattern_length_reg <= 5'd1;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                ridsf_pkg::CFG_PATTERN_LOW:    pattern_low_reg    <= cfg_data;
                ridsf_pkg::CFG_PATTERN_HIGH:   pattern_high_reg   <= cfg_data;
                ridsf_pkg::CFG_PATTERN_LENGTH: pattern_length_reg <= cfg_data[4:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        if (pattern_length_reg == 5'd0)
        begin
            used_len = UL_W'(1);
        end
        else if (32'(pattern_length_reg) > 32'(PATTERN_MAX))
        begin
            used_len = UL_W'(PATTERN_MAX);
        end
        else
        begin
            used_len = UL_W'(pattern_length_reg);
        end
    end

    ridsf_chain #(
        .PATTERN_MAX (PATTERN_MAX)
    ) u_chain (
        .clk          (clk),
        .shift_en     (accept),
        .data_byte    (data_byte),
        .pattern      ({pattern_high_reg, pattern_low_reg}),
        .used_len     (used_len),
        .chain_status (chain_status)
    );

    // Per-byte search, extend and result logic
    always_comb
    begin
        eff_last  = last || (32'(position_reg) >= 32'(BLOCK_BYTES - 1));
        printable = ridsf_pkg::is_printable(data_byte);
        is_term   = (data_byte == ridsf_pkg::CHAR_NUL) ||
                    (data_byte == ridsf_pkg::CHAR_CR)  ||
                    (data_byte == ridsf_pkg::CHAR_LF);
        p1        = FL_W'(position_reg) + FL_W'(1);

        trail_s = (data_byte == ridsf_pkg::CHAR_SPACE) ? trailing_reg + FL_W'(1) : '0;
        run_s   = (printable && ((position_reg == '0) || !chain_status.prev_printable)) ?
                  position_reg : run_begin_reg;
        match   = chain_status.hit && (32'(p1) >= 32'(used_len));
        mstart  = POS_W'(32'(p1) - 32'(used_len));
        start_s = (chain_status.pattern_printable && (run_s < mstart)) ? run_s : mstart;
        found_s = p1 - FL_W'(start_s);
        trail_c = (trail_s > found_s) ? found_s : trail_s;
        grow    = (32'(found_length_reg) < 32'(FORWARD_LIMIT)) && printable;

        position_next     = position_reg;
        run_begin_next    = run_begin_reg;
        phase_next        = phase_reg;
        found_length_next = found_length_reg;
        trailing_next     = trailing_reg;
        emit              = 1'b0;
        status_next       = ridsf_pkg::STATUS_NOT_FOUND;
        start_next        = '0;
        length_next       = '0;

        case (phase_reg)
            ridsf_pkg::PH_SEARCH:
            begin
                trailing_next  = trail_s;
                run_begin_next = run_s;
                if (match)
                begin
                    run_begin_next    = start_s;
                    found_length_next = found_s;
                    trailing_next     = trail_c;
                    if (eff_last)
                    begin
                        emit        = 1'b1;
                        status_next = ridsf_pkg::STATUS_FOUND;
                        start_next  = start_s;
                        length_next = found_s - trail_c;
                    end
                    else
                    begin
                        phase_next = ridsf_pkg::PH_EXTEND;
                    end
                end
                else if (eff_last)
                begin
                    emit = 1'b1;
                end
            end
            ridsf_pkg::PH_EXTEND:
            begin
                if (grow)
                begin
                    found_length_next = found_length_reg + FL_W'(1);
                    trailing_next = (data_byte == ridsf_pkg::CHAR_SPACE) ?
                                    trailing_reg + FL_W'(1) : '0;
                    if (eff_last)
                    begin
                        emit        = 1'b1;
                        status_next = ridsf_pkg::STATUS_FOUND;
                        start_next  = run_begin_reg;
                        length_next = found_length_next - trailing_next;
                    end
                end
                else
                begin
                    emit       = 1'b1;
                    phase_next = ridsf_pkg::PH_IDLE;
                    start_next = run_begin_reg;
                    if (is_term)
                    begin
                        status_next = ridsf_pkg::STATUS_FOUND;
                        length_next = found_length_reg - trailing_reg;
                    end
                    else
                    begin
                        status_next = ridsf_pkg::STATUS_REJECTED;
                        length_next = found_length_reg;
                    end
                end
            end
            default:
            begin
            end
        endcase

        if (eff_last)
        begin
            position_next     = '0;
            run_begin_next    = '0;
            phase_next        = ridsf_pkg::PH_SEARCH;
            found_length_next = '0;
            trailing_next     = '0;
        end
        else
        begin
            position_next = position_reg + POS_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            position_reg     <= '0;
            run_begin_reg    <= '0;
            phase_reg        <= ridsf_pkg::PH_SEARCH;
            found_length_reg <= '0;
            trailing_reg     <= '0;
        end
        else if (accept)
        begin
            position_reg     <= position_next;
            run_begin_reg    <= run_begin_next;
            phase_reg        <= phase_next;
            found_length_reg <= found_length_next;
            trailing_reg     <= trailing_next;
        end
    end

    always_comb
    begin
        if (accept && emit)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept && emit)
        begin
            status_reg <= status_next;
            start_reg  <= start_next;
            length_reg <= length_next;
        end
    end

    assign out_valid     = out_valid_reg;
    assign status        = status_reg;
    assign string_start  = ridsf_pkg::START_W'(start_reg);
    assign string_length = ridsf_pkg::LENGTH_W'(length_reg);

endmodule

`default_nettype wire

// ----- rtl/core/ridsf_checker.sv -----
// ridsf_checker: port-level assertions of the ID string finder, bound to the top.
// Depends on ridsf_pkg and rom_id_string_finder.
`default_nettype none

module ridsf_checker (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        in_valid,
    input wire logic        in_ready,
    input wire logic        out_valid,
    input wire logic        out_ready,
    input wire logic [1:0]  status,
    input wire logic [15:0] string_start,
    input wire logic [16:0] string_length
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(status) &&
            $stable(string_start) && $stable(string_length))
        else $error("result changed while stalled");

    a_stall_input: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |-> !in_ready)
        else $error("input taken while result register is full");

    a_result_cause: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(in_valid && in_ready))
        else $error("result without an accepted transaction");

    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (status == ridsf_pkg::STATUS_NOT_FOUND) ||
            (status == ridsf_pkg::STATUS_FOUND) ||
            (status == ridsf_pkg::STATUS_REJECTED))
        else $error("undefined status code");

    a_not_found_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (status == ridsf_pkg::STATUS_NOT_FOUND) |->
            (string_start == 16'd0) && (string_length == 17'd0))
        else $error("not-found result carries a string");

endmodule

bind rom_id_string_finder ridsf_checker u_ridsf_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .status        (status),
    .string_start  (string_start),
    .string_length (string_length)
);

`default_nettype wire

// ----- tb/sv/rom_id_string_finder_test.sv -----
`timescale 1ns / 100ps
// rom_id_string_finder_test: self-checking testbench of the ID string finder.
// Depends on ridsf_pkg and rom_id_string_finder; streams byte blocks through the
// block and checks every result against an in-bench scan of the same bytes.

module rom_id_string_finder_test;

    import ridsf_pkg::*;

    localparam int BLOCK_BYTES   = 65536;
    localparam int FORWARD_LIMIT = 256;
    localparam int CYCLE_LIMIT   = 1000000;

    typedef struct packed {
        logic [7:0] value;
        logic       ends;
    } rom_byte_t;

    typedef struct packed {
        logic [1:0]  outcome;
        logic [15:0] offset;
        logic [16:0] span;
    } id_report_t;

    logic        clk;
    logic        rst_n = 1'b0;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [1:0]  cfg_index = CFG_PATTERN_LOW;
    logic [63:0] cfg_data = '0;
    logic        in_valid = 1'b0;
    logic        in_ready;
    logic [7:0]  data_byte = 8'h00;
    logic        last = 1'b0;
    logic        out_valid;
    logic        out_ready = 1'b0;
    logic [1:0]  status;
    logic [15:0] string_start;
    logic [16:0] string_length;

    rom_byte_t   rom_bytes[$];
    id_report_t  pending_reports[$];
    int          mismatches = 0;
    int unsigned cycle_count = 0;
    bit          send_bursts = 1'b1;
    bit          take_bursts = 1'b1;
    int          send_hold = 0;
    int          take_hold = 0;

    logic [7:0]  probe [PATTERN_BYTES];
    int          probe_len = 1;

    logic [63:0] pattern_lo_r = '0;
    logic [63:0] pattern_hi_r = '0;
    logic [4:0]  pattern_len_r = 5'd1;

    logic [7:0]  window [PATTERN_BYTES] = '{default: 8'h00};
    logic [16:0] scan_pos = '0;
    logic [15:0] str_first = '0;
    logic [1:0]  scan_phase = PH_SEARCH;
    logic [16:0] str_len = '0;
    logic [16:0] space_run = '0;

    rom_id_string_finder u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .data_byte     (data_byte),
        .last          (last),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .status        (status),
        .string_start  (string_start),
        .string_length (string_length)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    function automatic logic shows_glyph(input logic [7:0] c);
        return (c >= CHAR_SPACE) && (c <= CHAR_TILDE);
    endfunction

    function automatic id_report_t found_report();
        logic [16:0] trim;
        trim = (space_run > str_len) ? str_len : space_run;
        return '{outcome: STATUS_FOUND, offset: str_first, span: str_len - trim};
    endfunction

    task automatic advance_scan(input logic [7:0] b, input logic closing);
        int         p;
        int         pl;
        int         i;
        int         k;
        int         mstart;
        int         first;
        logic       at_end;
        logic       hit;
        logic       pat_ok;
        logic [7:0] pb;
        p = scan_pos;
        at_end = closing || (p >= BLOCK_BYTES - 1);
        for (i = PATTERN_BYTES - 1; i > 0; i--)
            window[i] = window[i - 1];
        window[0] = b;
        if (scan_phase == PH_SEARCH)
        begin
            pl = pattern_len_r;
            if (pl < 1)
                pl = 1;
            if (pl > PATTERN_BYTES)
                pl = PATTERN_BYTES;
            hit = (p + 1) >= pl;
            pat_ok = 1'b1;
            if (b == CHAR_SPACE)
            begin
                if (space_run < 17'h1FFFF)
                    space_run++;
            end
            else
                space_run = '0;
            if (shows_glyph(b) && (p == 0 || !shows_glyph(window[1])))
                str_first = 16'(p);
            for (k = 0; k < pl; k++)
            begin
                pb = (k < 8) ? pattern_lo_r[8 * k +: 8] : pattern_hi_r[8 * (k - 8) +: 8];
                if (window[pl - 1 - k] != pb)
                    hit = 1'b0;
                if (!shows_glyph(pb))
                    pat_ok = 1'b0;
            end
            if (hit)
            begin
                mstart = p + 1 - pl;
                first = pat_ok ? int'(str_first) : mstart;
                if (first > mstart)
                    first = mstart;
                str_first = 16'(first);
                str_len = 17'(p + 1 - first);
                if (space_run > str_len)
                    space_run = str_len;
                if (at_end)
                    pending_reports.push_back(found_report());
                else
                    scan_phase = PH_EXTEND;
            end
            else if (at_end)
                pending_reports.push_back('{outcome: STATUS_NOT_FOUND, offset: '0, span: '0});
        end
        else if (scan_phase == PH_EXTEND)
        begin
            if (str_len < FORWARD_LIMIT && shows_glyph(b))
            begin
                str_len++;
                if (b == CHAR_SPACE)
                    space_run++;
                else
                    space_run = '0;
                if (at_end)
                    pending_reports.push_back(found_report());
            end
            else
            begin
                if (b == CHAR_NUL || b == CHAR_CR || b == CHAR_LF)
                    pending_reports.push_back(found_report());
                else
                    pending_reports.push_back('{outcome: STATUS_REJECTED,
                                                offset: str_first, span: str_len});
                scan_phase = PH_IDLE;
            end
        end
        if (at_end)
        begin
            window = '{default: 8'h00};
            scan_pos = '0;
            str_first = '0;
            scan_phase = PH_SEARCH;
            str_len = '0;
            space_run = '0;
        end
        else
            scan_pos = 17'(p + 1);
    endtask

    always @(posedge clk)
    begin
        if (rst_n && cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                CFG_PATTERN_LOW:    pattern_lo_r = cfg_data;
                CFG_PATTERN_HIGH:   pattern_hi_r = cfg_data;
                CFG_PATTERN_LENGTH: pattern_len_r = cfg_data[4:0];
                default: ;
            endcase
        end
    end

    always @(posedge clk or negedge rst_n)
    begin : drive_bytes
        rom_byte_t item;
        if (!rst_n)
        begin
            in_valid  <= 1'b0;
            data_byte <= 8'h00;
            last      <= 1'b0;
            send_hold = 0;
        end
        else
        begin
            if (in_valid && in_ready)
                advance_scan(data_byte, last);
            if (!in_valid || in_ready)
            begin
                if (send_hold > 0)
                begin
                    send_hold--;
                    in_valid <= 1'b0;
                end
                else if (rom_bytes.size() != 0 && send_bursts && $urandom_range(0, 9) == 0)
                begin
                    send_hold = $urandom_range(0, 15);
                    in_valid <= 1'b0;
                end
                else if (rom_bytes.size() != 0)
                begin
                    item = rom_bytes.pop_front();
                    in_valid  <= 1'b1;
                    data_byte <= item.value;
                    last      <= item.ends;
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    task automatic report_field(input string field, input logic [16:0] want_v,
                                input logic [16:0] got_v);
        mismatches++;
        $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want_v, got_v);
    endtask

    always @(posedge clk or negedge rst_n)
    begin : take_reports
        id_report_t due;
        if (!rst_n)
        begin
            out_ready <= 1'b0;
            take_hold = 0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                if (pending_reports.size() == 0)
                begin
                    mismatches++;
                    $display("%0t: unexpected result, expected none, actual %0d/%0d/%0d",
                             $time, status, string_start, string_length);
                end
                else
                begin
                    due = pending_reports.pop_front();
                    if (status !== due.outcome)
                        report_field("status", due.outcome, status);
                    if (string_start !== due.offset)
                        report_field("string_start", due.offset, string_start);
                    if (string_length !== due.span)
                        report_field("string_length", due.span, string_length);
                end
            end
            if (take_hold > 0)
            begin
                take_hold--;
                out_ready <= 1'b0;
            end
            else if (take_bursts && $urandom_range(0, 9) == 0)
            begin
                take_hold = $urandom_range(0, 15);
                out_ready <= 1'b0;
            end
            else
                out_ready <= 1'b1;
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("Regression FAIL");
            $finish;
        end
    end

    task automatic write_reg(input logic [1:0] index, input logic [63:0] value);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= index;
        cfg_data  <= value;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic load_pattern(input logic [127:0] bytes, input logic [4:0] len_code);
        logic [63:0] word;
        int          k;
        write_reg(CFG_PATTERN_LOW, bytes[63:0]);
        write_reg(CFG_PATTERN_HIGH, bytes[127:64]);
        word = {$urandom, $urandom};
        word[4:0] = len_code;
        write_reg(CFG_PATTERN_LENGTH, word);
        probe_len = (len_code == 0) ? 1 : (len_code > PATTERN_BYTES) ? PATTERN_BYTES : len_code;
        for (k = 0; k < PATTERN_BYTES; k++)
            probe[k] = bytes[8 * k +: 8];
    endtask

    function automatic logic [127:0] text_pattern(input string s);
        logic [127:0] v;
        int           k;
        v = '0;
        for (k = 0; k < s.len() && k < PATTERN_BYTES; k++)
            v[8 * k +: 8] = s[k];
        return v;
    endfunction

    function automatic logic [127:0] printable_bytes();
        logic [127:0] v;
        int           k;
        for (k = 0; k < PATTERN_BYTES; k++)
            v[8 * k +: 8] = 8'($urandom_range(32, 126));
        return v;
    endfunction

    function automatic logic [7:0] text_byte(input int space_odds);
        return ($urandom_range(1, space_odds) == 1) ? CHAR_SPACE : 8'($urandom_range(33, 126));
    endfunction

    task automatic add_byte(input logic [7:0] c, input logic closing);
        rom_bytes.push_back('{value: c, ends: closing});
    endtask

    task automatic add_text(input string s);
        int k;
        for (k = 0; k < s.len(); k++)
            add_byte(s[k], 1'b0);
    endtask

    task automatic settle();
        while (rom_bytes.size() != 0 || in_valid || pending_reports.size() != 0)
            @(negedge clk);
        repeat (8) @(posedge clk);
    endtask

    task automatic make_block(output int count);
        rom_byte_t  blk[$];
        int         kind;
        int         n;
        int         k;
        logic [7:0] c;
        kind = $urandom_range(0, 9);
        if (kind < 7)
        begin
            repeat ($urandom_range(0, 10))
                blk.push_back('{value: 8'($urandom_range(0, 255)), ends: 1'b0});
            n = ($urandom_range(0, 11) == 0) ? $urandom_range(240, 300) : $urandom_range(0, 8);
            repeat (n)
                blk.push_back('{value: text_byte(4), ends: 1'b0});
            for (k = 0; k < probe_len; k++)
            begin
                c = ($urandom_range(0, 9) == 0) ? 8'($urandom_range(0, 255)) : probe[k];
                blk.push_back('{value: c, ends: 1'b0});
            end
            n = ($urandom_range(0, 9) == 0) ? $urandom_range(250, 270) : $urandom_range(0, 12);
            repeat (n)
                blk.push_back('{value: text_byte(3), ends: 1'b0});
            repeat ($urandom_range(0, 3))
                blk.push_back('{value: CHAR_SPACE, ends: 1'b0});
            case ($urandom_range(0, 5))
                0: blk.push_back('{value: CHAR_NUL, ends: 1'b0});
                1: blk.push_back('{value: CHAR_CR, ends: 1'b0});
                2: blk.push_back('{value: CHAR_LF, ends: 1'b0});
                3: blk.push_back('{value: 8'($urandom_range(0, 255)), ends: 1'b0});
                4: blk.push_back('{value: 8'h7F, ends: 1'b0});
                default: ;
            endcase
            repeat ($urandom_range(0, 6))
                blk.push_back('{value: 8'($urandom_range(0, 255)), ends: 1'b0});
        end
        else if (kind < 9)
        begin
            repeat ($urandom_range(1, 24))
                blk.push_back('{value: 8'($urandom_range(0, 255)), ends: 1'b0});
        end
        else
        begin
            for (k = 0; k < probe_len - 1; k++)
                blk.push_back('{value: probe[k], ends: 1'b0});
            for (k = 0; k < probe_len; k++)
                blk.push_back('{value: probe[k], ends: 1'b0});
            repeat ($urandom_range(0, 4))
                blk.push_back('{value: text_byte(3), ends: 1'b0});
            blk.push_back('{value: CHAR_CR, ends: 1'b0});
        end
        blk[blk.size() - 1].ends = 1'b1;
        count = blk.size();
        foreach (blk[k])
            rom_bytes.push_back(blk[k]);
    endtask

    task automatic random_part(input int budget, input bit calm);
        int made;
        int n;
        send_bursts = !calm && ($urandom_range(0, 3) != 0);
        take_bursts = !calm && ($urandom_range(0, 3) != 0);
        made = 0;
        while (made < budget)
        begin
            make_block(n);
            made += n;
        end
        settle();
    endtask

    initial
    begin : run_scans
        logic [127:0] bytes;
        logic [7:0]   c;
        int           i;
        int           k;
        probe = '{default: 8'h00};
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        // lone NUL against the reset pattern, at block end
        add_byte(CHAR_NUL, 1'b1);
        settle();
        load_pattern(text_pattern("ID"), 5'd2);
        add_text(" xID  ");
        add_byte(CHAR_NUL, 1'b0);
        add_byte(8'hFF, 1'b1);
        add_text("I");
        add_byte("D", 1'b1);
        add_text("~ID!");
        add_byte(8'h7F, 1'b1);
        add_byte(8'h1F, 1'b0);
        add_byte("z", 1'b1);
        add_text("AID");
        add_byte(CHAR_CR, 1'b1);
        add_text("ID");
        add_byte(CHAR_LF, 1'b1);
        settle();

        load_pattern(text_pattern("ROM"), 5'd3);
        random_part(230, 1'b0);

        // overlong block: pattern lands on the final offset, no last flag
        send_bursts = 1'b0;
        take_bursts = 1'b0;
        for (i = 0; i < BLOCK_BYTES - probe_len; i++)
        begin
            do
                c = 8'($urandom_range(0, 255));
            while (c == probe[0]);
            add_byte(c, 1'b0);
        end
        for (k = 0; k < probe_len; k++)
            add_byte(probe[k], 1'b0);
        add_text("xROM");
        add_byte(CHAR_CR, 1'b1);
        settle();

        load_pattern(printable_bytes(), 5'd16);
        random_part(230, 1'b0);
        load_pattern(printable_bytes(), 5'd1);
        random_part(230, 1'b0);
        bytes = printable_bytes();
        bytes[15:8] = 8'h01;
        load_pattern(bytes, 5'd3);
        random_part(230, 1'b0);
        load_pattern(printable_bytes(), 5'd0);
        random_part(230, 1'b0);
        load_pattern(printable_bytes(), 5'd31);
        random_part(230, 1'b0);
        load_pattern({128{1'b1}}, 5'd2);
        random_part(200, 1'b0);
        load_pattern(printable_bytes(), 5'd17);
        random_part(200, 1'b0);
        load_pattern(printable_bytes(), 5'($urandom_range(2, 8)));
        random_part(230, 1'b1);

        if (mismatches == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

// ----- filelist.f -----
rtl/core/ridsf_pkg.sv
rtl/core/ridsf_cell.sv
rtl/core/ridsf_chain.sv
rtl/core/rom_id_string_finder.sv
rtl/core/ridsf_checker.sv
tb/sv/rom_id_string_finder_test.sv
